// ===== sv/tps_pkg.sv =====
// Shared constants and types for the target priority selector.
package tps_pkg;

	localparam int COORD_BITS = 12;
	localparam int AREA_BITS  = 20;
	localparam int CLASS_BITS = 4;
	localparam int SCORE_W    = 22;

	localparam int CLASS_STEP  = 1000;
	localparam int CLASS_TOP   = 6;
	localparam int PREF_BONUS  = 100000;
	localparam int DIST_WEIGHT = 2;
	localparam int BONUS_BITS  = 17;

	localparam int SCORE_MAX = 2 ** (SCORE_W - 1) - 1;
	localparam int SCORE_MIN = -(2 ** (SCORE_W - 1));

	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int SQ_W      = 2 * ROOT_BITS;
	localparam int REM_W     = ROOT_BITS + 2;
	localparam int CNT_W     = $clog2(ROOT_BITS + 1);

	localparam int SUM_A = (AREA_BITS > BONUS_BITS) ? AREA_BITS : BONUS_BITS;
	localparam int SUM_B = (SUM_A > COORD_BITS + 2) ? SUM_A : COORD_BITS + 2;
	localparam int SUM_C = (SUM_B > SCORE_W) ? SUM_B : SCORE_W;
	localparam int SUM_W = SUM_C + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_SCORE,
		ST_EMIT
	} tps_state_t;

endpackage

// ===== sv/tps_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module tps_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tps_pkg::SQ_W-1:0]      radicand,
	output logic                          busy,
	output logic [tps_pkg::ROOT_BITS-1:0] root
);
	import tps_pkg::*;

	logic [SQ_W-1:0]      rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 run_q;

	logic [REM_W-1:0]     shifted;
	logic [REM_W-1:0]     trial;
	logic                 take;
	logic [REM_W-1:0]     rem_nxt;
	logic [ROOT_BITS-1:0] root_nxt;

	always_comb begin
		shifted  = {rem_q[REM_W-3:0], rad_q[SQ_W-1:SQ_W-2]};
		trial    = {root_q, 2'b01};
		take     = (shifted >= trial);
		rem_nxt  = take ? (shifted - trial) : shifted;
		root_nxt = {root_q[ROOT_BITS-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(ROOT_BITS);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= rem_nxt;
			root_q <= root_nxt;
		end
	end

	assign busy = run_q;
	assign root = root_q;

endmodule

// ===== sv/target_priority_selector_top.sv =====
// Top level of the target priority selector: sequencer, scoring and best-target tracking.
//
//  Channel  Handshake                 Payload
//  cfg      cfg_wr_en                 cfg_wr_data (preferred class)
//  in       in_valid / in_ready       present, box_area, class_num, pos_x, pos_y, frame_end
//  out      out_valid / out_ready     found, sel_class, sel_x, sel_y, sel_area, sel_score
//
// A request with neither target nor frame end stays in ST_IDLE, a target with no reference goes
// to ST_SCORE, and one scored against a reference waits in ST_SQ and ST_ROOT on the bit-serial
// square root unit. A frame end passes through ST_EMIT to hand the result to the output register.
// Reset is asynchronous and clears the reference, the best target and the output register.
// The output register lets a new request enter while a result waits; a second frame end
// holds in its final cycle until the output register is free.
module target_priority_selector_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [tps_pkg::CLASS_BITS-1:0]         cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   present,
	input  logic [tps_pkg::AREA_BITS-1:0]          box_area,
	input  logic [tps_pkg::CLASS_BITS-1:0]         class_num,
	input  logic [tps_pkg::COORD_BITS-1:0]         pos_x,
	input  logic [tps_pkg::COORD_BITS-1:0]         pos_y,
	input  logic                                   frame_end,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   found,
	output logic [tps_pkg::CLASS_BITS-1:0]         sel_class,
	output logic [tps_pkg::COORD_BITS-1:0]         sel_x,
	output logic [tps_pkg::COORD_BITS-1:0]         sel_y,
	output logic [tps_pkg::AREA_BITS-1:0]          sel_area,
	output logic signed [tps_pkg::SCORE_W-1:0]     sel_score
);
	import tps_pkg::*;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SCORE_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SCORE_MIN);

	tps_state_t state_q, state_d;

	logic [CLASS_BITS-1:0] pref_q;
	logic [CLASS_BITS-1:0] ref_class_q;
	logic [COORD_BITS-1:0] ref_x_q, ref_y_q;

	logic [AREA_BITS-1:0]  area_q;
	logic [CLASS_BITS-1:0] class_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic                  fend_q;
	logic                  dist_q;

	logic                      best_valid_q;
	logic signed [SCORE_W-1:0] best_score_q;
	logic [CLASS_BITS-1:0]     best_class_q;
	logic [COORD_BITS-1:0]     best_x_q, best_y_q;
	logic [AREA_BITS-1:0]      best_area_q;

	logic                      out_valid_q;
	logic                      found_q;
	logic [CLASS_BITS-1:0]     sel_class_q;
	logic [COORD_BITS-1:0]     sel_x_q, sel_y_q;
	logic [AREA_BITS-1:0]      sel_area_q;
	logic signed [SCORE_W-1:0] sel_score_q;

	logic                    accept;
	logic                    root_start;
	logic                    root_busy;
	logic [ROOT_BITS-1:0]    root_val;
	logic                    emit_go;
	logic                    score_upd;

	logic [COORD_BITS-1:0]   dx, dy;
	logic [2*COORD_BITS-1:0] dx2, dy2;
	logic [SQ_W-1:0]         sq_sum;

	logic                      class_ok;
	logic [SUM_W-1:0]          area_u, cls_u, pref_u, dist_u;
	logic signed [SUM_W-1:0]   score_raw;
	logic signed [SCORE_W-1:0] score_sat;
	logic                      better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		root_start = 1'b0;
		score_upd  = 1'b0;
		emit_go    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (present) begin
						state_d = (ref_class_q != '0) ? ST_SQ : ST_SCORE;
					end else if (frame_end) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SQ: begin
				root_start = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				if (!root_busy) begin
					state_d = ST_SCORE;
				end
			end
			ST_SCORE: begin
				score_upd = 1'b1;
				state_d   = fend_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			area_q  <= box_area;
			class_q <= class_num;
			x_q     <= pos_x;
			y_q     <= pos_y;
			fend_q  <= frame_end;
			dist_q  <= (ref_class_q != '0);
		end
	end

	always_comb begin
		dx     = (x_q > ref_x_q) ? (x_q - ref_x_q) : (ref_x_q - x_q);
		dy     = (y_q > ref_y_q) ? (y_q - ref_y_q) : (ref_y_q - y_q);
		dx2    = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
		dy2    = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
		sq_sum = SQ_W'(dx2) + SQ_W'(dy2);
	end

	tps_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_sum),
		.busy     (root_busy),
		.root     (root_val)
	);

	always_comb begin
		class_ok  = (pref_q == '0) && (class_q >= CLASS_BITS'(1)) &&
			(class_q <= CLASS_BITS'(CLASS_TOP));
		area_u    = SUM_W'(area_q);
		cls_u     = class_ok ? (SUM_W'(class_q) * SUM_W'(CLASS_STEP)) : '0;
		pref_u    = (class_q == pref_q) ? SUM_W'(PREF_BONUS) : '0;
		dist_u    = dist_q ? (SUM_W'(root_val) * SUM_W'(DIST_WEIGHT)) : '0;
		score_raw = $signed(area_u + cls_u + pref_u - dist_u);
		if (score_raw > SAT_HI) begin
			score_sat = SCORE_W'(SCORE_MAX);
		end else if (score_raw < SAT_LO) begin
			score_sat = SCORE_W'(SCORE_MIN);
		end else begin
			score_sat = score_raw[SCORE_W-1:0];
		end
		better = !best_valid_q || (score_sat > best_score_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_q       <= '0;
			ref_class_q  <= '0;
			ref_x_q      <= '0;
			ref_y_q      <= '0;
			best_valid_q <= 1'b0;
			best_score_q <= '0;
			best_class_q <= '0;
			best_x_q     <= '0;
			best_y_q     <= '0;
			best_area_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				pref_q <= cfg_wr_data;
			end
			if (score_upd && better) begin
				best_valid_q <= 1'b1;
				best_score_q <= score_sat;
				best_class_q <= class_q;
				best_x_q     <= x_q;
				best_y_q     <= y_q;
				best_area_q  <= area_q;
			end else if (emit_go) begin
				ref_class_q  <= best_valid_q ? best_class_q : '0;
				ref_x_q      <= best_valid_q ? best_x_q : '0;
				ref_y_q      <= best_valid_q ? best_y_q : '0;
				best_valid_q <= 1'b0;
				best_score_q <= '0;
				best_class_q <= '0;
				best_x_q     <= '0;
				best_y_q     <= '0;
				best_area_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			sel_class_q <= '0;
			sel_x_q     <= '0;
			sel_y_q     <= '0;
			sel_area_q  <= '0;
			sel_score_q <= '0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
			found_q     <= best_valid_q;
			sel_class_q <= best_class_q;
			sel_x_q     <= best_x_q;
			sel_y_q     <= best_y_q;
			sel_area_q  <= best_area_q;
			sel_score_q <= best_score_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign sel_class = sel_class_q;
	assign sel_x     = sel_x_q;
	assign sel_y     = sel_y_q;
	assign sel_area  = sel_area_q;
	assign sel_score = sel_score_q;

`ifndef SYNTHESIS
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found || (sel_class == '0 && sel_area == '0 && sel_score == '0)))
		else $error("Not-found result carries a nonzero field.");

	a_root_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !root_busy)
		else $error("Square root unit busy while a new request can enter.");

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> !best_valid_q)
		else $error("Best target survived the end of its frame.");

	a_root_started: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |=> root_busy)
		else $error("Square root unit did not start.");
`endif

endmodule
